FILE: hw/rtl/dsc_pkg.sv
// Package for the double-exponential synapse conductance block.
// Holds the widths, register codes, reset values, shared types and saturation helpers.
// No dependencies; every other file of the block but dsc_ram imports it.
package dsc_pkg;

   // Ring of delay slots. The depth must be a power of two so the index wraps by truncation.
   localparam int DELAY_SLOTS = 64;
   localparam int SLOT_AW     = $clog2(DELAY_SLOTS);

   // Field widths of the item and result channels.
   localparam int DELAY_W    = 6;
   localparam int WEIGHT_W   = 32;
   localparam int MULT_W     = 8;
   localparam int G_W        = 48;
   localparam int G_SUM_W    = G_W + 1;
   localparam int PROD_W     = 40;
   localparam int FACTOR_W   = 32;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 2 * G_W;

   // Bit positions of the fields inside req_tdata.
   localparam int DELAY_LSB  = 0;
   localparam int WEIGHT_LSB = DELAY_LSB + DELAY_W;
   localparam int MULT_LSB   = WEIGHT_LSB + WEIGHT_W;

   // Width of the pointer-plus-delay sum before it wraps onto the ring.
   localparam int SUM_W = ((SLOT_AW > DELAY_W) ? SLOT_AW : DELAY_W) + 1;

   // Multiplier split: the magnitude is cut into two 24-bit halves.
   localparam int NORM_FRAC   = 24;
   localparam int TRACE_FRAC  = 31;
   localparam int HALF_W      = NORM_FRAC;
   localparam int EXTRA_SHIFT = TRACE_FRAC - NORM_FRAC;
   localparam int MAG_W       = HALF_W + FACTOR_W;

   // Queue between the front and the back part.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_RISE_FACTOR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FALL_FACTOR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_NORM   = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [FACTOR_W-1:0] RISE_FACTOR_RESET = 32'd1302514674;
   localparam logic [FACTOR_W-1:0] FALL_FACTOR_RESET = 32'd2104961324;
   localparam logic [FACTOR_W-1:0] PEAK_NORM_RESET   = 32'd19984000;
   localparam logic [FACTOR_W-1:0] FACTOR_ONE        = 32'h8000_0000;

   // Limits of the signed 48-bit conductance range.
   localparam logic signed [G_W-1:0] G_MAX = {1'b0, {(G_W-1){1'b1}}};
   localparam logic signed [G_W-1:0] G_MIN = {1'b1, {(G_W-1){1'b0}}};

   // Command carried in req_tuser.
   localparam logic CMD_SPIKE = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   // Tags of the three products that one tick needs.
   typedef enum logic [1:0] {
      OP_RISE,
      OP_NORM,
      OP_FALL
   } op_type;

   // Back part sequencer states.
   typedef enum logic [2:0] {
      B_IDLE,
      B_SPIKE,
      B_TK_NORM,
      B_TK_FALL,
      B_TK_WAIT,
      B_TK_FIN
   } back_state_type;

   // One classified item as it waits in the queue.
   typedef struct packed {
      logic                      is_tick;
      logic [DELAY_W-1:0]        delay;
      logic signed [PROD_W-1:0]  prod;
   } q_entry_type;

   // Configuration registers as seen by the back part.
   typedef struct packed {
      logic [FACTOR_W-1:0] rise_factor;
      logic [FACTOR_W-1:0] fall_factor;
      logic [FACTOR_W-1:0] peak_norm;
   } cfg_type;

   // Request into the shared multiply-shift unit.
   typedef struct packed {
      logic                  vld;
      op_type                tag;
      logic signed [G_W-1:0] value;
      logic [FACTOR_W-1:0]   factor;
      logic                  is_norm;
   } mul_req_type;

   // Result out of the shared multiply-shift unit.
   typedef struct packed {
      logic                  vld;
      op_type                tag;
      logic signed [G_W-1:0] value;
   } mul_rsp_type;

   // Saturate a 49-bit sum to the signed 48-bit range.
   function automatic logic signed [G_W-1:0] sat_g(input logic signed [G_SUM_W-1:0] v);
      logic signed [G_W-1:0] r;
      if (v[G_SUM_W-1] != v[G_W-1]) begin
         r = v[G_SUM_W-1] ? G_MIN : G_MAX;
      end else begin
         r = v[G_W-1:0];
      end
      return r;
   endfunction

   // A decay factor above one is treated as exactly one.
   function automatic logic [FACTOR_W-1:0] clamp_factor(input logic [FACTOR_W-1:0] f);
      return (f > FACTOR_ONE) ? FACTOR_ONE : f;
   endfunction

endpackage

FILE: hw/rtl/dsc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the delay slot ring of the synapse block.
module dsc_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/dsc_front.sv
// Front part: accepts items, classifies them and queues them for the back part.
// Depends on dsc_pkg for the field widths and the queue entry type.
module dsc_front
   import dsc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic                       req_command,
   input  logic [DELAY_W-1:0]         req_delay_steps,
   input  logic signed [WEIGHT_W-1:0] req_weight,
   input  logic [MULT_W-1:0]          req_multiplicity,
   output logic                       q_valid,
   output q_entry_type                q_head,
   input  logic                       q_pop
);

   q_entry_type               q_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]         count_ff, count_in;
   logic                      push;
   logic signed [PROD_W-1:0]  prod_full;
   q_entry_type               entry;

   // Spike contribution is formed here, so the back part only adds it.
   // A 32-bit weight times an 8-bit multiplicity always fits in 40 signed bits.
   assign prod_full = PROD_W'(req_weight) * PROD_W'($signed({1'b0, req_multiplicity}));

   always_comb begin
      entry.is_tick = (req_command == CMD_TICK);
      entry.delay   = req_delay_steps;
      entry.prod    = prod_full;
   end

   // Queue occupancy and pointers.
   assign req_tready = (count_ff != (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != '0);
   assign q_head     = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

FILE: hw/rtl/dsc_mulsh.sv
// Shared five-stage multiply-shift unit: (value * factor) >> 31 or >> 24,
// truncated toward zero and saturated to 48 bits. Depends on dsc_pkg.
module dsc_mulsh
   import dsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output mul_rsp_type rsp
);

   logic                  neg;
   logic [G_W-1:0]        mag;

   logic                  s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff;
   op_type                s1_tag_ff, s2_tag_ff, s3_tag_ff, s4_tag_ff, s5_tag_ff;
   logic                  s1_neg_ff, s2_neg_ff, s3_neg_ff, s4_neg_ff;
   logic                  s1_norm_ff, s2_norm_ff, s3_norm_ff;
   logic [G_W-1:0]        s1_mag_ff;
   logic [FACTOR_W-1:0]   s1_fac_ff, s2_fac_ff;
   logic [HALF_W-1:0]     s2_ah_ff;
   logic [MAG_W-1:0]      s2_lo_ff, s3_lo_ff, s3_hi_ff, s4_mag_ff;
   logic signed [G_W-1:0] s5_value_ff;

   logic [MAG_W-1:0]      lo_prod, hi_prod, upper, shifted;
   logic signed [G_W-1:0] sat_value;

   // Magnitude and sign of the operand.
   assign neg = req.value[G_W-1];
   assign mag = neg ? G_W'(-req.value) : G_W'(req.value);

   // Low and high partial products, one per stage.
   assign lo_prod = MAG_W'(s1_mag_ff[HALF_W-1:0]) * MAG_W'(s1_fac_ff);
   assign hi_prod = MAG_W'(s2_ah_ff) * MAG_W'(s2_fac_ff);

   // Recombine: the sum of both halves shifted right by 24, then by 7 more for traces.
   assign upper   = s3_hi_ff + MAG_W'(s3_lo_ff[MAG_W-1:HALF_W]);
   assign shifted = s3_norm_ff ? upper : (upper >> EXTRA_SHIFT);

   // Restore the sign and saturate.
   always_comb begin
      if (s4_neg_ff) begin
         if (s4_mag_ff[MAG_W-1:G_W-1] != '0) begin
            sat_value = G_MIN;
         end else begin
            sat_value = -$signed(s4_mag_ff[G_W-1:0]);
         end
      end else begin
         if (s4_mag_ff[MAG_W-1:G_W-1] != '0) begin
            sat_value = G_MAX;
         end else begin
            sat_value = $signed(s4_mag_ff[G_W-1:0]);
         end
      end
   end

   // Stage valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= req.vld;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      s1_tag_ff   <= req.tag;
      s1_neg_ff   <= neg;
      s1_norm_ff  <= req.is_norm;
      s1_mag_ff   <= mag;
      s1_fac_ff   <= req.factor;

      s2_tag_ff   <= s1_tag_ff;
      s2_neg_ff   <= s1_neg_ff;
      s2_norm_ff  <= s1_norm_ff;
      s2_ah_ff    <= s1_mag_ff[G_W-1:HALF_W];
      s2_fac_ff   <= s1_fac_ff;
      s2_lo_ff    <= lo_prod;

      s3_tag_ff   <= s2_tag_ff;
      s3_neg_ff   <= s2_neg_ff;
      s3_norm_ff  <= s2_norm_ff;
      s3_lo_ff    <= s2_lo_ff;
      s3_hi_ff    <= hi_prod;

      s4_tag_ff   <= s3_tag_ff;
      s4_neg_ff   <= s3_neg_ff;
      s4_mag_ff   <= shifted;

      s5_tag_ff   <= s4_tag_ff;
      s5_value_ff <= sat_value;
   end

   always_comb begin
      rsp.vld   = s5_vld_ff;
      rsp.tag   = s5_tag_ff;
      rsp.value = s5_value_ff;
   end

endmodule

FILE: hw/rtl/dsc_back.sv
// Back part: sequences spikes and ticks over the slot ring, the traces and the result register.
// Depends on dsc_pkg, dsc_ram (slot ring) and dsc_mulsh (shared multiply-shift unit).
module dsc_back
   import dsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  q_valid,
   input  q_entry_type           q_head,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic signed [G_W-1:0] rsp_conductance,
   output logic signed [G_W-1:0] rsp_previous
);

   back_state_type           state_ff, state_in;
   logic signed [G_W-1:0]    rise_ff, fall_ff, last_ff;
   logic [SLOT_AW-1:0]       ptr_ff;
   logic [DELAY_SLOTS-1:0]   slot_vld_ff;
   logic [SLOT_AW-1:0]       spk_addr_ff;
   logic signed [PROD_W-1:0] spk_prod_ff;
   logic signed [G_W-1:0]    cap_rise_ff, cap_norm_ff, cap_fall_ff;
   logic                     out_valid_ff;
   logic signed [G_W-1:0]    out_cond_ff, out_prev_ff;

   mul_req_type              mul_req;
   mul_rsp_type              mul_rsp;
   logic                     rd_en, wr_en;
   logic [SLOT_AW-1:0]       rd_addr;
   logic [G_W-1:0]           rd_data;
   logic [SUM_W-1:0]         spike_sum_addr;
   logic [SLOT_AW-1:0]       spike_addr;
   logic signed [G_W-1:0]    slot_old, slot_cur, spike_sum;
   logic signed [G_W-1:0]    g_new, rise_new, fall_new;
   logic                     spk_load, fin;

   // Slot ring storage; an entry without its valid bit reads as zero.
   dsc_ram #(
      .WIDTH (G_W),
      .DEPTH (DELAY_SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (spk_addr_ff),
      .wr_data (spike_sum),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dsc_mulsh u_mulsh (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   // Target slot of a spike, wrapped onto the ring.
   assign spike_sum_addr = SUM_W'(ptr_ff) + SUM_W'(q_head.delay);
   assign spike_addr     = spike_sum_addr[SLOT_AW-1:0];

   // Slot read values and the saturating spike accumulation.
   assign slot_old  = slot_vld_ff[spk_addr_ff] ? $signed(rd_data) : '0;
   assign slot_cur  = slot_vld_ff[ptr_ff] ? $signed(rd_data) : '0;
   assign spike_sum = sat_g(G_SUM_W'(slot_old) + G_SUM_W'(spk_prod_ff));

   // Tick finish: conductance, then the normalized slot moves from rise to fall trace.
   assign g_new    = sat_g(G_SUM_W'(cap_rise_ff) + G_SUM_W'(cap_fall_ff));
   assign rise_new = sat_g(G_SUM_W'(cap_rise_ff) - G_SUM_W'(cap_norm_ff));
   assign fall_new = sat_g(G_SUM_W'(cap_fall_ff) + G_SUM_W'(cap_norm_ff));

   // Sequencer: next state and control strobes.
   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = ptr_ff;
      wr_en    = 1'b0;
      spk_load = 1'b0;
      fin      = 1'b0;
      mul_req  = '0;
      unique case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               rd_en = 1'b1;
               if (q_head.is_tick) begin
                  mul_req.vld    = 1'b1;
                  mul_req.tag    = OP_RISE;
                  mul_req.value  = rise_ff;
                  mul_req.factor = clamp_factor(cfg.rise_factor);
                  state_in       = B_TK_NORM;
               end else begin
                  rd_addr  = spike_addr;
                  spk_load = 1'b1;
                  state_in = B_SPIKE;
               end
            end
         end
         B_SPIKE: begin
            wr_en    = 1'b1;
            state_in = B_IDLE;
         end
         B_TK_NORM: begin
            mul_req.vld     = 1'b1;
            mul_req.tag     = OP_NORM;
            mul_req.value   = slot_cur;
            mul_req.factor  = cfg.peak_norm;
            mul_req.is_norm = 1'b1;
            state_in        = B_TK_FALL;
         end
         B_TK_FALL: begin
            mul_req.vld    = 1'b1;
            mul_req.tag    = OP_FALL;
            mul_req.value  = fall_ff;
            mul_req.factor = clamp_factor(cfg.fall_factor);
            state_in       = B_TK_WAIT;
         end
         B_TK_WAIT: begin
            if (mul_rsp.vld && (mul_rsp.tag == OP_FALL)) begin
               state_in = B_TK_FIN;
            end
         end
         B_TK_FIN: begin
            if (!out_valid_ff || rsp_tready) begin
               fin      = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // Control state: sequencer, traces, slot pointer, valid bits and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rise_ff      <= '0;
         fall_ff      <= '0;
         last_ff      <= '0;
         ptr_ff       <= '0;
         slot_vld_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (wr_en) begin
            slot_vld_ff[spk_addr_ff] <= 1'b1;
         end
         if (fin) begin
            rise_ff             <= rise_new;
            fall_ff             <= fall_new;
            last_ff             <= g_new;
            ptr_ff              <= ptr_ff + SLOT_AW'(1);
            slot_vld_ff[ptr_ff] <= 1'b0;
            out_valid_ff        <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: spike operands, captured products and the result.
   always_ff @(posedge clock) begin
      if (spk_load) begin
         spk_addr_ff <= spike_addr;
         spk_prod_ff <= q_head.prod;
      end
      if (mul_rsp.vld) begin
         case (mul_rsp.tag)
            OP_RISE: cap_rise_ff <= mul_rsp.value;
            OP_NORM: cap_norm_ff <= mul_rsp.value;
            OP_FALL: cap_fall_ff <= mul_rsp.value;
            default: ;
         endcase
      end
      if (fin) begin
         out_cond_ff <= g_new;
         out_prev_ff <= last_ff;
      end
   end

   assign rsp_tvalid      = out_valid_ff;
   assign rsp_conductance = out_cond_ff;
   assign rsp_previous    = out_prev_ff;

endmodule

FILE: hw/rtl/dual_exponential_synapse_conductance.sv
// Double-exponential synapse conductance window with a rise and a decay trace.
// Depends on dsc_pkg, dsc_front, dsc_back (which holds dsc_ram and dsc_mulsh).
//
// Usage:
//   req_*  : item stream. req_tuser is the command (0 spike, 1 tick). A spike adds
//            weight * multiplicity into the slot delay_steps ticks ahead; a tick
//            decays both traces, returns one result and drains the current slot.
//   rsp_*  : one result per tick: the new and the previous conductance.
//   csr_*  : register writes, always ready; write only while the block is idle.
// Timing:
//   The front part takes one item per cycle while its four-entry queue has room.
//   The back part handles a spike as a slot read, then an add and write back, and a
//   tick as three products that go through the shared five-stage multiply-shift unit.
// Reset:
//   Synchronous, active high. Traces, previous conductance and slot pointer clear,
//   every slot reads as zero through its valid bit, registers take their defaults.
// Stall:
//   The result waits in its output register; a following tick holds in its last
//   step and the queue fills, after which req_tready drops.
module dual_exponential_synapse_conductance
   import dsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_tuser,  // command
   input  logic [REQ_DATA_W-1:0] req_tdata,  // delay_steps, weight, multiplicity, zero pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // conductance, previous_conductance
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [FACTOR_W-1:0]   csr_data
);

   cfg_type               cfg_ff;
   q_entry_type           q_head;
   logic                  q_valid, q_pop;
   logic signed [G_W-1:0] rsp_conductance, rsp_previous;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rise_factor <= RISE_FACTOR_RESET;
         cfg_ff.fall_factor <= FALL_FACTOR_RESET;
         cfg_ff.peak_norm   <= PEAK_NORM_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RISE_FACTOR: cfg_ff.rise_factor <= csr_data;
            CSR_FALL_FACTOR: cfg_ff.fall_factor <= csr_data;
            CSR_PEAK_NORM:   cfg_ff.peak_norm   <= csr_data;
            default: ;
         endcase
      end
   end

   dsc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_command      (req_tuser),
      .req_delay_steps  (req_tdata[DELAY_LSB +: DELAY_W]),
      .req_weight       ($signed(req_tdata[WEIGHT_LSB +: WEIGHT_W])),
      .req_multiplicity (req_tdata[MULT_LSB +: MULT_W]),
      .q_valid          (q_valid),
      .q_head           (q_head),
      .q_pop            (q_pop)
   );

   dsc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_valid         (q_valid),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_conductance (rsp_conductance),
      .rsp_previous    (rsp_previous)
   );

   // Result packing: conductance in the low half.
   assign rsp_tdata = {rsp_previous, rsp_conductance};

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the double-exponential synapse conductance block.
// Drives spike and tick items, predicts every conductance result, and checks each one.
// Depends on dsc_pkg and the block's RTL only.
module tb_top;
   import dsc_pkg::*;

   localparam int SETTLE_CYCLES = 40;
   localparam int STALL_LIMIT   = 2000;
   localparam int MAX_REPORTS   = 50;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam longint COND_MAX = 64'sd140737488355327;
   localparam longint COND_MIN = -64'sd140737488355328;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic                  req_tuser  = 1'b0;  // command
   logic [REQ_DATA_W-1:0] req_tdata  = '0;    // delay_steps, weight, multiplicity, zero pad
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // conductance, previous_conductance
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [FACTOR_W-1:0]   csr_data   = '0;

   dual_exponential_synapse_conductance uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // One expected result: the new conductance and the one from the tick before.
   typedef struct {
      logic [G_W-1:0] g;
      logic [G_W-1:0] g_prev;
   } conductance_pair_type;

   conductance_pair_type conductance_due[$];
   int error_count     = 0;
   int stall_left      = 0;
   int quiet_cycles    = 0;
   bit sender_idles    = 1'b0;
   bit receiver_stalls = 1'b0;

   // Predicted state of the synapse.
   logic [FACTOR_W-1:0] rise_factor_m;
   logic [FACTOR_W-1:0] fall_factor_m;
   logic [FACTOR_W-1:0] norm_m;
   longint              rise_m;
   longint              fall_m;
   longint              last_g_m;
   longint              slot_m[DELAY_SLOTS];
   int                  slot_ptr_m;

   function automatic longint clip48(longint v);
      if (v > COND_MAX) return COND_MAX;
      if (v < COND_MIN) return COND_MIN;
      return v;
   endfunction

   // Trace times an unsigned fixed-point factor, shifted down, truncated toward zero.
   function automatic longint scale_q(longint t, logic [FACTOR_W-1:0] f, int sh);
      logic [79:0] mag;
      logic [47:0] t_abs;
      longint      t_pos;
      t_pos = (t < 0) ? -t : t;
      t_abs = t_pos[47:0];
      mag   = ({32'd0, t_abs} * {48'd0, f}) >> sh;
      if (t < 0) begin
         return (mag > 80'(COND_MAX) + 1) ? COND_MIN : -longint'(mag);
      end
      return (mag > 80'(COND_MAX)) ? COND_MAX : longint'(mag);
   endfunction

   function automatic logic [FACTOR_W-1:0] at_most_one(logic [FACTOR_W-1:0] f);
      return (f > FACTOR_ONE) ? FACTOR_ONE : f;
   endfunction

   function automatic void deposit_spike(logic [DELAY_W-1:0] delay, logic signed [31:0] weight,
                                         logic [MULT_W-1:0] mult);
      int slot;
      slot = (slot_ptr_m + delay) % DELAY_SLOTS;
      slot_m[slot] = clip48(slot_m[slot] + longint'(weight) * longint'(mult));
   endfunction

   // A tick decays both traces, emits the conductance pair, then drains the current slot.
   function automatic void decay_and_drain();
      conductance_pair_type pair;
      longint               g;
      longint               n;
      rise_m = scale_q(rise_m, at_most_one(rise_factor_m), TRACE_FRAC);
      fall_m = scale_q(fall_m, at_most_one(fall_factor_m), TRACE_FRAC);
      g = clip48(rise_m + fall_m);
      pair.g      = g[G_W-1:0];
      pair.g_prev = last_g_m[G_W-1:0];
      conductance_due.insert(conductance_due.size(), pair);
      last_g_m = g;
      n = scale_q(slot_m[slot_ptr_m], norm_m, NORM_FRAC);
      slot_m[slot_ptr_m] = 0;
      rise_m = clip48(rise_m - n);
      fall_m = clip48(fall_m + n);
      slot_ptr_m = (slot_ptr_m + 1) % DELAY_SLOTS;
   endfunction

   task automatic reset_model();
      rise_factor_m = RISE_FACTOR_RESET;
      fall_factor_m = FALL_FACTOR_RESET;
      norm_m        = PEAK_NORM_RESET;
      rise_m        = 0;
      fall_m        = 0;
      last_g_m      = 0;
      slot_ptr_m    = 0;
      foreach (slot_m[i]) slot_m[i] = 0;
   endtask

   task automatic report_mismatch(string what);
      if (error_count < MAX_REPORTS) $display("MISMATCH at %0t: %s", $time, what);
      error_count++;
   endtask

   // Send one item. Valid stays high after acceptance, so callers either send the next
   // item or stop the stream in the same time step.
   task automatic send_item(logic cmd, logic [DELAY_W-1:0] delay, logic [31:0] weight,
                            logic [MULT_W-1:0] mult);
      int gap;
      gap = sender_idles ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, mult, weight, delay};
      do @(posedge clock); while (!req_tready);
      if (cmd == CMD_TICK) decay_and_drain();
      else deposit_spike(delay, weight, mult);
   endtask

   // Stop sending and wait until every expected result has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (conductance_due.size() != 0);
   endtask

   // Drain, then give trailing spikes time to leave the pipeline.
   task automatic settle_block();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all three registers back to back, optionally with a write to an unmapped index.
   task automatic program_registers(logic [31:0] rise, logic [31:0] fall, logic [31:0] norm,
                                    bit poke_unmapped);
      logic [CSR_IDX_W-1:0] idx[$];
      logic [FACTOR_W-1:0]  val[$];
      idx = '{CSR_RISE_FACTOR, CSR_FALL_FACTOR, CSR_PEAK_NORM};
      val = '{rise, fall, norm};
      if (poke_unmapped) begin
         idx.insert(1, CSR_UNMAPPED);
         val.insert(1, $urandom);
      end
      settle_block();
      foreach (idx[i]) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         do @(posedge clock); while (!csr_ready);
         case (idx[i])
            CSR_RISE_FACTOR: rise_factor_m = val[i];
            CSR_FALL_FACTOR: fall_factor_m = val[i];
            CSR_PEAK_NORM:   norm_m        = val[i];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // Ticks straight after reset give zero; spike fields on a tick must be ignored.
   task automatic test_idle_ticks();
      sender_idles    = 1'b0;
      receiver_stalls = 1'b0;
      send_item(CMD_TICK, '0, '0, '0);
      send_item(CMD_TICK, 6'h3F, 32'hFFFF_FFFF, 8'hFF);
      send_item(CMD_TICK, '0, '0, '0);
   endtask

   // Field extremes, zero delay, zero multiplicity and trace saturation under extreme registers.
   task automatic test_spike_extremes();
      sender_idles    = 1'b1;
      receiver_stalls = 1'b1;
      send_item(CMD_SPIKE, 6'd0, 32'h7FFF_FFFF, 8'd255);
      send_item(CMD_SPIKE, 6'd63, 32'h8000_0000, 8'd255);
      send_item(CMD_SPIKE, 6'd1, 32'h0001_0000, 8'd1);
      send_item(CMD_SPIKE, 6'd2, 32'h7FFF_FFFF, 8'd0);
      send_item(CMD_SPIKE, 6'd2, 32'hFFFF_FFFF, 8'd1);
      repeat (4) send_item(CMD_TICK, '0, '0, '0);
      send_item(CMD_TICK, 6'h2A, 32'h5555_AAAA, 8'h55);

      // Unity factors and the largest norm push the traces into saturation.
      program_registers(FACTOR_ONE, FACTOR_ONE, 32'hFFFF_FFFF, 1'b1);
      repeat (2) send_item(CMD_SPIKE, 6'd0, 32'h7FFF_FFFF, 8'd255);
      repeat (2) send_item(CMD_TICK, '0, '0, '0);
      repeat (2) send_item(CMD_SPIKE, 6'd1, 32'h8000_0000, 8'd255);
      repeat (3) send_item(CMD_TICK, '0, '0, '0);

      // Factors above one behave as one.
      program_registers(32'hFFFF_FFFF, 32'h8000_0001, 32'h0100_0000, 1'b0);
      repeat (2) send_item(CMD_TICK, '0, '0, '0);

      // All registers at zero.
      program_registers('0, '0, '0, 1'b0);
      send_item(CMD_SPIKE, 6'd0, 32'h0123_4567, 8'd3);
      repeat (2) send_item(CMD_TICK, '0, '0, '0);
   endtask

   // Enough full-scale spikes into two slots to saturate one slot sum upward and the other downward.
   task automatic test_slot_saturation();
      program_registers(RISE_FACTOR_RESET, FALL_FACTOR_RESET, PEAK_NORM_RESET, 1'b0);
      sender_idles    = 1'b0;
      receiver_stalls = 1'b1;
      repeat (270) send_item(CMD_SPIKE, 6'd3, 32'h7FFF_FFFF, 8'd255);
      sender_idles = 1'b1;
      repeat (270) send_item(CMD_SPIKE, 6'd4, 32'h8000_0000, 8'd255);
      repeat (8) send_item(CMD_TICK, '0, '0, '0);
   endtask

   // Random spikes and ticks under one register setting, with varying idle patterns.
   task automatic test_random_traffic(logic [31:0] rise, logic [31:0] fall, logic [31:0] norm,
                                      bit poke_unmapped, int count);
      logic        cmd;
      logic [31:0] weight;
      logic [7:0]  mult;
      program_registers(rise, fall, norm, poke_unmapped);
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0) begin
            sender_idles    = $urandom_range(0, 1);
            receiver_stalls = $urandom_range(0, 1);
         end
         // Halfway through, hold off until the block has returned everything.
         if (i == count / 2) drain_results();
         cmd = ($urandom_range(0, 99) < 40) ? CMD_TICK : CMD_SPIKE;
         case ($urandom_range(0, 9))
            0:       weight = 32'h7FFF_FFFF;
            1:       weight = 32'h8000_0000;
            2:       weight = $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
            default: weight = $urandom;
         endcase
         mult = ($urandom_range(0, 9) == 0) ? 8'd255 : 8'($urandom_range(0, 255));
         send_item(cmd, 6'($urandom_range(0, 63)), weight, mult);
      end
   endtask

   // Result side: random stalls, and each accepted result is checked against the oldest
   // expectation.
   always @(posedge clock) begin : rsp_side
      conductance_pair_type want;
      int                   draw;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (conductance_due.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected: %h", rsp_tdata));
         end else begin
            want = conductance_due.pop_front();
            if (rsp_tdata[G_W-1:0] !== want.g)
               report_mismatch($sformatf("conductance got %h want %h",
                                         rsp_tdata[G_W-1:0], want.g));
            if (rsp_tdata[2*G_W-1:G_W] !== want.g_prev)
               report_mismatch($sformatf("previous conductance got %h want %h",
                                         rsp_tdata[2*G_W-1:G_W], want.g_prev));
         end
         draw = receiver_stalls ? $urandom_range(0, 8) : 0;
         if (draw > 0) begin
            rsp_tready <= 1'b0;
            stall_left <= draw - 1;
         end
      end else if (!rsp_tready) begin
         if (stall_left == 0) rsp_tready <= 1'b1;
         else stall_left <= stall_left - 1;
      end
   end

   // Watchdog: too long without any accepted item, result or register write.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[dual_exponential_synapse_conductance] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset_model();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_idle_ticks();
      test_spike_extremes();
      test_slot_saturation();
      test_random_traffic(RISE_FACTOR_RESET, FALL_FACTOR_RESET, PEAK_NORM_RESET, 1'b1, 200);
      test_random_traffic(FACTOR_ONE, FACTOR_ONE, 32'hFFFF_FFFF, 1'b0, 200);
      test_random_traffic(32'hFFFF_FFFF, $urandom_range(32'h8000_0001, 32'hFFFF_FFFF),
                          $urandom, 1'b0, 200);
      test_random_traffic($urandom_range(0, FACTOR_ONE), $urandom_range(0, FACTOR_ONE),
                          $urandom_range(0, 32'h0400_0000), 1'b1, 200);
      test_random_traffic('0, '0, $urandom, 1'b0, 100);
      test_random_traffic($urandom_range(0, FACTOR_ONE), $urandom_range(0, FACTOR_ONE),
                          '0, 1'b0, 100);
      test_random_traffic($urandom_range(32'h6000_0000, FACTOR_ONE),
                          $urandom_range(32'h7000_0000, FACTOR_ONE), $urandom, 1'b0, 100);

      settle_block();
      if (error_count == 0) $display("[dual_exponential_synapse_conductance] OK");
      else $display("[dual_exponential_synapse_conductance] ERROR");
      $finish;
   end

endmodule
